// ===== hw/rtl/maxlhc_pkg.sv =====
// Shared constants, configuration and control types for the maximin Latin
// hypercube sampler. Used by the datapath, the controller and the top level.
// Depends on nothing.
`default_nettype none

package maxlhc_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_DIMS    = 8;
  localparam int MAX_DUP     = 4;
  localparam int RAND_BITS   = 32;
  localparam int MAX_POOL    = MAX_DUP * (MAX_SAMPLES - 1);

  localparam int SW    = $clog2(MAX_SAMPLES);          // sample index
  localparam int NW    = SW + 1;                       // level, N
  localparam int DW    = $clog2(MAX_DIMS);             // dimension index
  localparam int KW    = DW + 1;                       // K
  localparam int DUPW  = $clog2(MAX_DUP) + 1;          // dup factor
  localparam int LW    = $clog2(MAX_POOL + 1);         // pool length
  localparam int SHW   = $clog2(MAX_POOL);             // shuffle list address
  localparam int AV_DEPTH = MAX_DIMS * MAX_SAMPLES;
  localparam int AVW   = $clog2(AV_DEPTH);
  localparam int PL_DEPTH = MAX_DIMS * MAX_POOL;
  localparam int PLW   = $clog2(PL_DEPTH);
  localparam int SQW   = 2 * NW;
  localparam int DISTW = SQW + DW;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_NUM_SAMPLES = 2'd0;
  localparam logic [1:0] REG_NUM_DIMS    = 2'd1;
  localparam logic [1:0] REG_DUP_FACTOR  = 2'd2;

  typedef struct packed {
    logic [NW-1:0]   n;
    logic [KW-1:0]   k;
    logic [DUPW-1:0] dup;
  } maxlhc_cfg_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLR,
    CMD_TAKE,
    CMD_P0,
    CMD_FILL_INIT,
    CMD_FILL_RD,
    CMD_FILL_WR,
    CMD_PICK,
    CMD_RD_A,
    CMD_RD_B,
    CMD_SWAP,
    CMD_SC_INIT,
    CMD_CAND_RD,
    CMD_CAND_WR,
    CMD_P_INIT,
    CMD_PL_RD,
    CMD_PL_ACC,
    CMD_J_END,
    CMD_CM_INIT,
    CMD_CM_RDV,
    CMD_CM_RDR,
    CMD_CM_WR,
    CMD_SCAN_RD,
    CMD_SCAN_WR,
    CMD_CM_END,
    CMD_EMIT
  } maxlhc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic phase1;
    logic cnt_zero;
    logic cnt_one;
    logic dim_last;
    logic fill_last;
    logic len_small;
    logic e_last;
    logic p_last;
    logic j_last;
    logic emit_zero;
  } maxlhc_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/maximin_latin_hypercube_sampler.sv =====
// Maximin Latin hypercube sampler, top level: configuration registers and
// the stream ports. Depends on maxlhc_pkg, maxlhc_ctrl and maxlhc_dp.
//
// Usage: random fractions arrive on the s_ channel, one per transfer. The
// first K randoms of a run place point N-1; each column c from N-1 down to 1
// then takes K*dup*c randoms, and after the last one the chosen point c-1
// leaves on the m_ channel as K transfers, one per dimension, with tlast on
// the last dimension and tuser set on the last coordinate of point 0.
// Order of work: a placement random writes one level of point N-1; a shuffle
// pick moves one level into the pool, and the first pick of each dimension
// first copies the levels. After the column's last random, scoring walks the
// placed points through the single read port of the placed-point memory,
// then the commit scans the level table, then K result transfers follow.
// One random is worked on at a time. Reset and every register write start a
// new run with a clearing pass over all 512 entries of the level table,
// during which no random is accepted. A stalled receiver holds the block in
// the result transfer; nothing is lost.
`default_nettype none

module maximin_latin_hypercube_sampler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] rand_fraction
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [5:0] sample_index, [8:6] dim_index, [15:9] level
  output logic             m_tlast,   // last_of_point
  output logic [0:0]       m_tuser,   // [0] design_done
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NW   = maxlhc_pkg::NW;
  localparam int KW   = maxlhc_pkg::KW;
  localparam int DUPW = maxlhc_pkg::DUPW;

  logic [6:0] num_samples;
  logic [3:0] num_dims;
  logic [2:0] dup_factor;
  logic       cfg_wr;

  maxlhc_pkg::maxlhc_cfg_t    cfg;
  maxlhc_pkg::maxlhc_cmd_t    cmd;
  maxlhc_pkg::maxlhc_status_t status;

  logic [maxlhc_pkg::SW-1:0] o_sample;
  logic [maxlhc_pkg::DW-1:0] o_dim;
  logic [NW-1:0]             o_level;
  logic                      o_last, o_done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[3:2] == maxlhc_pkg::REG_NUM_SAMPLES ||
                   paddr[3:2] == maxlhc_pkg::REG_NUM_DIMS ||
                   paddr[3:2] == maxlhc_pkg::REG_DUP_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= 7'd2;
      num_dims    <= 4'd1;
      dup_factor  <= 3'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        maxlhc_pkg::REG_NUM_SAMPLES: num_samples <= pwdata[6:0];
        maxlhc_pkg::REG_NUM_DIMS:    num_dims    <= pwdata[3:0];
        maxlhc_pkg::REG_DUP_FACTOR:  dup_factor  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      maxlhc_pkg::REG_NUM_SAMPLES: prdata = {25'd0, num_samples};
      maxlhc_pkg::REG_NUM_DIMS:    prdata = {28'd0, num_dims};
      maxlhc_pkg::REG_DUP_FACTOR:  prdata = {29'd0, dup_factor};
      default:                     prdata = '0;
    endcase
  end

  // Out-of-range values are clamped into the supported range.
  always_comb begin
    if (num_samples == '0)
      cfg.n = NW'(1);
    else if (num_samples > 7'(maxlhc_pkg::MAX_SAMPLES))
      cfg.n = NW'(maxlhc_pkg::MAX_SAMPLES);
    else
      cfg.n = NW'(num_samples);
    if (num_dims == '0)
      cfg.k = KW'(1);
    else if (num_dims > 4'(maxlhc_pkg::MAX_DIMS))
      cfg.k = KW'(maxlhc_pkg::MAX_DIMS);
    else
      cfg.k = KW'(num_dims);
    if (dup_factor == '0)
      cfg.dup = DUPW'(1);
    else if (dup_factor > 3'(maxlhc_pkg::MAX_DUP))
      cfg.dup = DUPW'(maxlhc_pkg::MAX_DUP);
    else
      cfg.dup = DUPW'(dup_factor);
  end

  maxlhc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .cmd(cmd)
  );

  maxlhc_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .status(status),
    .in_data(s_tdata),
    .out_sample(o_sample), .out_dim(o_dim), .out_level(o_level),
    .out_last(o_last), .out_done(o_done)
  );

  assign m_tdata = {o_level, o_dim, o_sample};
  assign m_tlast = o_last;
  assign m_tuser = o_done;

endmodule

`default_nettype wire

// ===== hw/rtl/maxlhc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module maxlhc_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/maxlhc_dp.sv =====
// Datapath of the sampler: level tables, placed points, candidate pool,
// shuffle list, counters and the distance arithmetic.
// Depends on maxlhc_pkg and maxlhc_ram.
`default_nettype none

module maxlhc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire maxlhc_pkg::maxlhc_cfg_t       cfg,
  input  wire maxlhc_pkg::maxlhc_cmd_t       cmd,
  output maxlhc_pkg::maxlhc_status_t         status,
  input  wire logic [maxlhc_pkg::RAND_BITS-1:0] in_data,
  output logic [maxlhc_pkg::SW-1:0]          out_sample,
  output logic [maxlhc_pkg::DW-1:0]          out_dim,
  output logic [maxlhc_pkg::NW-1:0]          out_level,
  output logic                               out_last,
  output logic                               out_done
);

  localparam int SW    = maxlhc_pkg::SW;
  localparam int NW    = maxlhc_pkg::NW;
  localparam int DW    = maxlhc_pkg::DW;
  localparam int KW    = maxlhc_pkg::KW;
  localparam int LW    = maxlhc_pkg::LW;
  localparam int SHW   = maxlhc_pkg::SHW;
  localparam int AVW   = maxlhc_pkg::AVW;
  localparam int PLW   = maxlhc_pkg::PLW;
  localparam int SQW   = maxlhc_pkg::SQW;
  localparam int DISTW = maxlhc_pkg::DISTW;
  localparam int RB    = maxlhc_pkg::RAND_BITS;
  localparam int DUPW_X = maxlhc_pkg::DUPW + SW - LW + 1;

  // Run state.
  logic [RB-1:0]    u;
  logic [SW-1:0]    col;
  logic [DW-1:0]    dim;
  logic [LW-1:0]    cnt;
  logic             phase;
  logic [AVW-1:0]   clr;
  logic [LW-1:0]    len;
  logic [LW-1:0]    fill_t;
  logic [SW-1:0]    fill_i;
  logic [SHW-1:0]   pick_idx;
  logic [NW-1:0]    val_a;
  logic [LW-1:0]    j;
  logic [SW-1:0]    p;
  logic [DW-1:0]    e;
  logic [NW-1:0]    cand [maxlhc_pkg::MAX_DIMS];
  logic [NW-1:0]    olev [maxlhc_pkg::MAX_DIMS];
  logic [DISTW-1:0] acc;
  logic [DISTW-1:0] mn;
  logic [DISTW-1:0] best_score;
  logic [LW-1:0]    best;
  logic [NW-1:0]    cm_v;
  logic [NW-1:0]    cm_repl;
  logic [SW-1:0]    emit_p;
  logic [2*SW-1:0]  nm1_sq;
  logic [DISTW-1:0] mn_init;

  // Memory ports.
  logic           av_we, pp_we, po_we, sh_we;
  logic [AVW-1:0] av_waddr, av_raddr, pp_waddr, pp_raddr;
  logic [NW-1:0]  av_wdata, av_rdata, pp_wdata, pp_rdata;
  logic [PLW-1:0] po_waddr, po_raddr;
  logic [NW-1:0]  po_wdata, po_rdata, sh_wdata, sh_rdata;
  logic [SHW-1:0] sh_waddr, sh_raddr;

  // Arithmetic.
  logic [SW-1:0]       nm1;
  logic [SW-1:0]       cm1;
  logic [RB+NW-1:0]    prod0;
  logic [NW-1:0]       idx0;
  logic [NW-1:0]       lev0;
  logic [RB+LW-1:0]    prod1;
  logic [LW+DUPW_X-1:0] len_full;
  logic signed [NW:0]  diff;
  logic [SQW-1:0]      sq;
  logic [DISTW-1:0]    acc_sum;

  function automatic logic [PLW-1:0] pool_addr(input logic [DW-1:0] ed,
                                               input logic [LW-1:0] jj);
    pool_addr = PLW'(ed) * PLW'(maxlhc_pkg::MAX_POOL) + PLW'(jj);
  endfunction

  assign nm1   = SW'(cfg.n - NW'(1));
  assign cm1   = col - SW'(1);
  assign prod0 = (RB+NW)'(u) * (RB+NW)'(cfg.n);
  assign idx0  = prod0[RB +: NW];
  assign lev0  = idx0 + NW'(1);
  assign prod1 = (RB+LW)'(u) * (RB+LW)'(cnt);
  assign len_full = (LW+DUPW_X)'(col) * (LW+DUPW_X)'(cfg.dup);
  assign diff  = $signed({1'b0, cand[e]}) - $signed({1'b0, pp_rdata});
  assign sq    = SQW'(diff * diff);
  assign acc_sum = acc + DISTW'(sq);

  always_comb begin
    status.clr_last  = (clr == AVW'(maxlhc_pkg::AV_DEPTH - 1));
    status.phase1    = phase;
    status.cnt_zero  = (cnt == '0);
    status.cnt_one   = (cnt == LW'(1));
    status.dim_last  = ({1'b0, dim} == cfg.k - KW'(1));
    status.fill_last = (fill_t == len - LW'(1));
    status.len_small = (len < LW'(2));
    status.e_last    = ({1'b0, e} == cfg.k - KW'(1));
    status.p_last    = ({1'b0, p} == cfg.n - NW'(1));
    status.j_last    = (j == len - LW'(2));
    status.emit_zero = (emit_p == '0);
  end

  always_comb begin
    av_we = 1'b0; av_waddr = '0; av_wdata = '0; av_raddr = '0;
    pp_we = 1'b0; pp_waddr = '0; pp_wdata = '0; pp_raddr = '0;
    po_we = 1'b0; po_waddr = '0; po_wdata = '0; po_raddr = '0;
    sh_we = 1'b0; sh_waddr = '0; sh_wdata = '0; sh_raddr = '0;
    case (cmd)
      maxlhc_pkg::CMD_CLR: begin
        av_we    = 1'b1;
        av_waddr = clr;
        av_wdata = (NW'(clr[SW-1:0]) < cfg.n) ? NW'(clr[SW-1:0]) + NW'(1) : '0;
      end
      maxlhc_pkg::CMD_P0: begin
        av_we    = 1'b1;
        av_waddr = {dim, idx0[SW-1:0]};
        av_wdata = cfg.n;
        pp_we    = 1'b1;
        pp_waddr = {dim, nm1};
        pp_wdata = lev0;
      end
      maxlhc_pkg::CMD_FILL_RD: av_raddr = {dim, fill_i};
      maxlhc_pkg::CMD_FILL_WR: begin
        sh_we    = 1'b1;
        sh_waddr = SHW'(fill_t);
        sh_wdata = av_rdata;
      end
      maxlhc_pkg::CMD_RD_A: sh_raddr = pick_idx;
      maxlhc_pkg::CMD_RD_B: sh_raddr = SHW'(cnt - LW'(1));
      maxlhc_pkg::CMD_SWAP: begin
        po_we    = 1'b1;
        po_waddr = pool_addr(dim, cnt - LW'(1));
        po_wdata = val_a;
        sh_we    = 1'b1;
        sh_waddr = pick_idx;
        sh_wdata = sh_rdata;
      end
      maxlhc_pkg::CMD_CAND_RD: po_raddr = pool_addr(e, j);
      maxlhc_pkg::CMD_PL_RD:   pp_raddr = {e, p};
      maxlhc_pkg::CMD_CM_RDV:  po_raddr = pool_addr(e, best);
      maxlhc_pkg::CMD_CM_RDR:  av_raddr = {e, cm1};
      maxlhc_pkg::CMD_CM_WR: begin
        pp_we    = 1'b1;
        pp_waddr = {e, cm1};
        pp_wdata = cm_v;
      end
      maxlhc_pkg::CMD_SCAN_RD: av_raddr = {e, p};
      maxlhc_pkg::CMD_SCAN_WR: begin
        av_we    = (av_rdata == cm_v);
        av_waddr = {e, p};
        av_wdata = cm_repl;
      end
      default: ;
    endcase
  end

  // The squared span bound is fixed for a whole run, so it is kept registered.
  always_ff @(posedge clk) begin
    nm1_sq  <= (2*SW)'(nm1) * (2*SW)'(nm1);
    mn_init <= DISTW'(cfg.k) * DISTW'(nm1_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      col   <= '0;
      dim   <= '0;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      clr <= (cmd == maxlhc_pkg::CMD_CLR) ? clr + AVW'(1) : '0;
      case (cmd)
        maxlhc_pkg::CMD_CLR: begin
          col   <= nm1;
          dim   <= '0;
          cnt   <= '0;
          phase <= 1'b0;
        end
        maxlhc_pkg::CMD_TAKE: u <= in_data;
        maxlhc_pkg::CMD_P0: begin
          olev[dim] <= lev0;
          if (status.dim_last) begin
            dim    <= '0;
            phase  <= 1'b1;
            emit_p <= nm1;
            e      <= '0;
          end else begin
            dim <= dim + DW'(1);
          end
        end
        maxlhc_pkg::CMD_FILL_INIT: begin
          len    <= LW'(len_full);
          fill_t <= '0;
          fill_i <= '0;
        end
        maxlhc_pkg::CMD_FILL_WR: begin
          fill_t <= fill_t + LW'(1);
          fill_i <= (fill_i == cm1) ? '0 : fill_i + SW'(1);
          if (status.fill_last) begin
            cnt <= len;
          end
        end
        maxlhc_pkg::CMD_PICK: pick_idx <= SHW'(prod1[RB +: LW]);
        maxlhc_pkg::CMD_RD_B: val_a <= sh_rdata;
        maxlhc_pkg::CMD_SWAP: begin
          cnt <= cnt - LW'(1);
          if (status.cnt_one) begin
            dim <= status.dim_last ? '0 : dim + DW'(1);
          end
        end
        maxlhc_pkg::CMD_SC_INIT: begin
          j          <= '0;
          best       <= '0;
          best_score <= '0;
          e          <= '0;
        end
        maxlhc_pkg::CMD_CAND_WR: begin
          cand[e] <= po_rdata;
          e       <= status.e_last ? '0 : e + DW'(1);
        end
        maxlhc_pkg::CMD_P_INIT: begin
          p   <= col;
          mn  <= mn_init;
          acc <= '0;
          e   <= '0;
        end
        maxlhc_pkg::CMD_PL_ACC: begin
          if (status.e_last) begin
            if (acc_sum < mn) begin
              mn <= acc_sum;
            end
            acc <= '0;
            e   <= '0;
            p   <= p + SW'(1);
          end else begin
            acc <= acc_sum;
            e   <= e + DW'(1);
          end
        end
        maxlhc_pkg::CMD_J_END: begin
          // Only a strictly larger score replaces the best; the first wins ties.
          if (mn > best_score) begin
            best_score <= mn;
            best       <= j;
          end
          j <= j + LW'(1);
          e <= '0;
        end
        maxlhc_pkg::CMD_CM_INIT: e <= '0;
        maxlhc_pkg::CMD_CM_RDR:  cm_v <= po_rdata;
        maxlhc_pkg::CMD_CM_WR: begin
          cm_repl <= av_rdata;
          olev[e] <= cm_v;
          p       <= '0;
        end
        maxlhc_pkg::CMD_SCAN_WR: begin
          if (status.p_last) begin
            e <= e + DW'(1);
          end else begin
            p <= p + SW'(1);
          end
        end
        maxlhc_pkg::CMD_CM_END: begin
          emit_p <= cm1;
          col    <= cm1;
          e      <= '0;
        end
        maxlhc_pkg::CMD_EMIT: e <= status.e_last ? '0 : e + DW'(1);
        default: ;
      endcase
    end
  end

  assign out_sample = emit_p;
  assign out_dim    = e;
  assign out_level  = olev[e];
  assign out_last   = status.e_last;
  assign out_done   = status.e_last && status.emit_zero;

  maxlhc_ram #(.WIDTH(NW), .DEPTH(maxlhc_pkg::AV_DEPTH)) u_avail (
    .clk(clk), .we(av_we), .waddr(av_waddr), .wdata(av_wdata),
    .raddr(av_raddr), .rdata(av_rdata)
  );

  maxlhc_ram #(.WIDTH(NW), .DEPTH(maxlhc_pkg::AV_DEPTH)) u_placed (
    .clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
    .raddr(pp_raddr), .rdata(pp_rdata)
  );

  maxlhc_ram #(.WIDTH(NW), .DEPTH(maxlhc_pkg::PL_DEPTH)) u_pool (
    .clk(clk), .we(po_we), .waddr(po_waddr), .wdata(po_wdata),
    .raddr(po_raddr), .rdata(po_rdata)
  );

  maxlhc_ram #(.WIDTH(NW), .DEPTH(maxlhc_pkg::MAX_POOL)) u_shuffle (
    .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
    .raddr(sh_raddr), .rdata(sh_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/maxlhc_ctrl.sv =====
// Controller of the sampler: sequences table clearing, placement, shuffle
// picks, scoring, commit and result transfer. Depends on maxlhc_pkg.
`default_nettype none

module maxlhc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  input  wire maxlhc_pkg::maxlhc_status_t status,
  output maxlhc_pkg::maxlhc_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_P0, S_FILL_INIT, S_FILL_RD, S_FILL_WR, S_PICK, S_RD_A,
    S_RD_B, S_SWAP, S_SC_INIT, S_CAND_RD, S_CAND_WR, S_P_INIT, S_PL_RD,
    S_PL_ACC, S_J_END, S_CM_INIT, S_CM_RDV, S_CM_RDR, S_CM_WR, S_SCAN_RD,
    S_SCAN_WR, S_CM_END, S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = maxlhc_pkg::CMD_NOP;
    case (state)
      S_CLEAR: begin
        if (!cfg_wr) begin
          cmd = maxlhc_pkg::CMD_CLR;
          if (status.clr_last) state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = maxlhc_pkg::CMD_TAKE;
          if (!status.phase1)       state_next = S_P0;
          else if (status.cnt_zero) state_next = S_FILL_INIT;
          else                      state_next = S_PICK;
        end
      end
      S_P0: begin
        cmd = maxlhc_pkg::CMD_P0;
        state_next = status.dim_last ? S_EMIT : S_IDLE;
      end
      S_FILL_INIT: begin
        cmd = maxlhc_pkg::CMD_FILL_INIT;
        state_next = S_FILL_RD;
      end
      S_FILL_RD: begin
        cmd = maxlhc_pkg::CMD_FILL_RD;
        state_next = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd = maxlhc_pkg::CMD_FILL_WR;
        state_next = status.fill_last ? S_PICK : S_FILL_RD;
      end
      S_PICK: begin
        cmd = maxlhc_pkg::CMD_PICK;
        state_next = S_RD_A;
      end
      S_RD_A: begin
        cmd = maxlhc_pkg::CMD_RD_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd = maxlhc_pkg::CMD_RD_B;
        state_next = S_SWAP;
      end
      S_SWAP: begin
        cmd = maxlhc_pkg::CMD_SWAP;
        state_next = (status.cnt_one && status.dim_last) ? S_SC_INIT : S_IDLE;
      end
      S_SC_INIT: begin
        cmd = maxlhc_pkg::CMD_SC_INIT;
        state_next = status.len_small ? S_CM_INIT : S_CAND_RD;
      end
      S_CAND_RD: begin
        cmd = maxlhc_pkg::CMD_CAND_RD;
        state_next = S_CAND_WR;
      end
      S_CAND_WR: begin
        cmd = maxlhc_pkg::CMD_CAND_WR;
        state_next = status.e_last ? S_P_INIT : S_CAND_RD;
      end
      S_P_INIT: begin
        cmd = maxlhc_pkg::CMD_P_INIT;
        state_next = S_PL_RD;
      end
      S_PL_RD: begin
        cmd = maxlhc_pkg::CMD_PL_RD;
        state_next = S_PL_ACC;
      end
      S_PL_ACC: begin
        cmd = maxlhc_pkg::CMD_PL_ACC;
        state_next = (status.e_last && status.p_last) ? S_J_END : S_PL_RD;
      end
      S_J_END: begin
        cmd = maxlhc_pkg::CMD_J_END;
        state_next = status.j_last ? S_CM_INIT : S_CAND_RD;
      end
      S_CM_INIT: begin
        cmd = maxlhc_pkg::CMD_CM_INIT;
        state_next = S_CM_RDV;
      end
      S_CM_RDV: begin
        cmd = maxlhc_pkg::CMD_CM_RDV;
        state_next = S_CM_RDR;
      end
      S_CM_RDR: begin
        cmd = maxlhc_pkg::CMD_CM_RDR;
        state_next = S_CM_WR;
      end
      S_CM_WR: begin
        cmd = maxlhc_pkg::CMD_CM_WR;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd = maxlhc_pkg::CMD_SCAN_RD;
        state_next = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        cmd = maxlhc_pkg::CMD_SCAN_WR;
        if (!status.p_last)     state_next = S_SCAN_RD;
        else if (status.e_last) state_next = S_CM_END;
        else                    state_next = S_CM_RDV;
      end
      S_CM_END: begin
        cmd = maxlhc_pkg::CMD_CM_END;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd = maxlhc_pkg::CMD_EMIT;
          if (status.e_last) state_next = status.emit_zero ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    // A register write abandons the run and reloads the level tables.
    if (cfg_wr) begin
      state_next = S_CLEAR;
      if (state != S_CLEAR) cmd = maxlhc_pkg::CMD_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

endmodule

`default_nettype wire

// ===== tb/sv/maximin_latin_hypercube_sampler_tb.sv =====
// Self-checking testbench for the maximin Latin hypercube sampler: random
// fractions in, emitted coordinates checked against a behavioral predictor.
// Depends on maxlhc_pkg and the maximin_latin_hypercube_sampler top level.
`timescale 1ns / 1ps

module maximin_latin_hypercube_sampler_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [5:0] sample_index;
    logic [2:0] dim_index;
    logic [6:0] level;
    logic       last_of_point;
    logic       design_done;
  } coord_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  maximin_latin_hypercube_sampler dut (.*);

  // Predictor state.
  int unsigned cfg_n, cfg_k, cfg_dup;
  int unsigned avail[maxlhc_pkg::MAX_DIMS*maxlhc_pkg::MAX_SAMPLES];
  int unsigned placed[maxlhc_pkg::MAX_DIMS*maxlhc_pkg::MAX_SAMPLES];
  int unsigned pool[maxlhc_pkg::MAX_DIMS*maxlhc_pkg::MAX_POOL];
  int unsigned shuf[maxlhc_pkg::MAX_POOL];
  int unsigned column, dim_cnt, picks_left;
  bit          shuffling;

  logic [31:0] rand_fracs[$];
  coord_t      coords_due[$];
  int          n_errors = 0, n_items = 0, n_coords = 0, n_cfg = 0;
  int          send_idle_pct = 0, rcv_idle_pct = 0, rcv_hold = 0;
  bit          send_paused = 0, in_taken = 0;
  int          quiet_cycles = 0;

  initial forever #10 clk = ~clk;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned pick_index(logic [31:0] u, int unsigned m);
    logic [63:0] prod;
    prod = {32'b0, u} * 64'(m);
    return (prod >> 32) >= m ? m - 1 : int'(prod >> 32);
  endfunction

  function automatic void restart_design();
    int unsigned n;
    n = clampu(cfg_n, 1, maxlhc_pkg::MAX_SAMPLES);
    for (int d = 0; d < maxlhc_pkg::MAX_DIMS; d++)
      for (int j = 0; j < maxlhc_pkg::MAX_SAMPLES; j++)
        avail[d*maxlhc_pkg::MAX_SAMPLES+j] = j < n ? j + 1 : 0;
    column = n - 1;
    dim_cnt = 0;
    picks_left = 0;
    shuffling = 0;
  endfunction

  function automatic void emit_coords(int unsigned p, int unsigned k);
    coord_t c;
    for (int unsigned d = 0; d < k; d++) begin
      c.sample_index  = p[5:0];
      c.dim_index     = d[2:0];
      c.level         = placed[d*maxlhc_pkg::MAX_SAMPLES+p][6:0];
      c.last_of_point = (d + 1 == k);
      c.design_done   = (d + 1 == k) && (p == 0);
      coords_due.push_back(c);
    end
  endfunction

  // Works out the coordinates that one accepted random fraction completes.
  function automatic void predict_fraction(logic [31:0] u);
    int unsigned n, k, dup, d, c, len, jcol, idx, lev, best, best_score, mn, sq_dist, v, repl;
    int diff;
    n = clampu(cfg_n, 1, maxlhc_pkg::MAX_SAMPLES);
    k = clampu(cfg_k, 1, maxlhc_pkg::MAX_DIMS);
    dup = clampu(cfg_dup, 1, maxlhc_pkg::MAX_DUP);
    d = dim_cnt % maxlhc_pkg::MAX_DIMS;
    if (!shuffling) begin
      lev = pick_index(u, n) + 1;
      placed[d*maxlhc_pkg::MAX_SAMPLES+n-1] = lev;
      avail[d*maxlhc_pkg::MAX_SAMPLES+lev-1] = n;
      dim_cnt = d + 1;
      if (dim_cnt < k) return;
      dim_cnt = 0;
      emit_coords(n - 1, k);
      if (n == 1) restart_design();
      else shuffling = 1;
      return;
    end
    c = clampu(column, 1, n - 1);
    len = c * dup;
    if (picks_left == 0) begin
      for (int unsigned j = 0; j < dup; j++)
        for (int unsigned i = 0; i < c; i++)
          shuf[i+c*j] = avail[d*maxlhc_pkg::MAX_SAMPLES+i];
      picks_left = len;
    end
    jcol = clampu(picks_left, 1, len);
    idx = pick_index(u, jcol);
    pool[d*maxlhc_pkg::MAX_POOL+jcol-1] = shuf[idx];
    shuf[idx] = shuf[jcol-1];
    picks_left = jcol - 1;
    if (picks_left != 0) return;
    dim_cnt = d + 1;
    if (dim_cnt < k) return;
    dim_cnt = 0;
    // The final candidate of the pool is deliberately left unscored.
    best = 0;
    best_score = 0;
    for (int unsigned j = 0; j + 1 < len; j++) begin
      mn = k * (n - 1) * (n - 1);
      for (int unsigned p = c; p < n; p++) begin
        sq_dist = 0;
        for (int unsigned e = 0; e < k; e++) begin
          diff = int'(pool[e*maxlhc_pkg::MAX_POOL+j]) -
                 int'(placed[e*maxlhc_pkg::MAX_SAMPLES+p]);
          sq_dist += diff * diff;
        end
        if (sq_dist < mn) mn = sq_dist;
      end
      if (mn > best_score) begin
        best_score = mn;
        best = j;
      end
    end
    for (int unsigned i = 0; i < k; i++) begin
      v = pool[i*maxlhc_pkg::MAX_POOL+best];
      repl = avail[i*maxlhc_pkg::MAX_SAMPLES+c-1];
      placed[i*maxlhc_pkg::MAX_SAMPLES+c-1] = v;
      for (int unsigned j = 0; j < n; j++)
        if (avail[i*maxlhc_pkg::MAX_SAMPLES+j] == v) avail[i*maxlhc_pkg::MAX_SAMPLES+j] = repl;
    end
    emit_coords(c - 1, k);
    if (c == 1) restart_design();
    else column = c - 1;
  endfunction

  // Input side: record transfers at the rising edge, drive at the falling edge.
  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      predict_fraction(s_tdata);
      void'(rand_fracs.pop_front());
      n_items++;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_taken)) begin
      if (rand_fracs.size() > 0 && !send_paused && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= rand_fracs[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      rcv_hold <= rcv_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && $urandom_range(99) >= rcv_idle_pct;
    end
  end

  // Output side checking and the watchdog.
  always @(posedge clk) begin
    coord_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_coords++;
      if (coords_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected coordinate tdata=%h tlast=%b tuser=%b",
                   m_tdata, m_tlast, m_tuser);
      end else begin
        e = coords_due.pop_front();
        if (m_tdata[5:0] !== e.sample_index || m_tdata[8:6] !== e.dim_index ||
            m_tdata[15:9] !== e.level || m_tlast !== e.last_of_point ||
            m_tuser[0] !== e.design_done) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: point %0d dim %0d level %0d last %b done %b, got %0d %0d %0d %b %b",
                     e.sample_index, e.dim_index, e.level, e.last_of_point, e.design_done,
                     m_tdata[5:0], m_tdata[8:6], m_tdata[15:9], m_tlast, m_tuser[0]);
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d quiet cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      maxlhc_pkg::REG_NUM_SAMPLES: cfg_n   = value & 127;
      maxlhc_pkg::REG_NUM_DIMS:    cfg_k   = value & 15;
      maxlhc_pkg::REG_DUP_FACTOR:  cfg_dup = value & 7;
      default: ;
    endcase
    restart_design();
    n_cfg++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int unsigned n, int unsigned k, int unsigned dup);
    write_reg(maxlhc_pkg::REG_NUM_SAMPLES, n);
    write_reg(maxlhc_pkg::REG_NUM_DIMS, k);
    write_reg(maxlhc_pkg::REG_DUP_FACTOR, dup);
  endtask

  // Waits until all queued fractions went out and every coordinate came back,
  // then lets a pick that produced nothing finish inside the block.
  task automatic drain();
    wait (rand_fracs.size() == 0 && coords_due.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [31:0] random_fraction();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return {1'b1, 31'($urandom_range(255))};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cfg_n = 2;
    cfg_k = 1;
    cfg_dup = 1;
    restart_design();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: default settings with the extreme fractions.
    rand_fracs = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF};
    drain();
    // A single point with the widest dimension count finishes a run at once.
    configure(1, 8, 4);
    rand_fracs = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h1, 32'hFFFF_FFFE,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h0};
    drain();
    // Out-of-range values are clamped: zero points, too many dims and dups.
    configure(0, 15, 7);
    rand_fracs = '{32'h1234_5678, 32'hFFFF_FFFF, 32'h0};
    drain();
    // Largest design: only its first point and a few picks are exercised.
    configure(127, 8, 0);
    for (int i = 0; i < 10; i++) rand_fracs.push_back(i[0] ? 32'hFFFF_FFFF : 32'h0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = ph < 3 ? 13 : (ph < 6 ? 88 : 0);
      rcv_idle_pct  = ph < 3 ? 88 : (ph < 6 ? 13 : 0);
      configure($urandom_range(2, 5), $urandom_range(1, 3), $urandom_range(1, 3));
      for (int i = 0; i < 26; i++) rand_fracs.push_back(random_fraction());
      if (ph == 6) begin
        rcv_hold = 400;
        wait (rand_fracs.size() < 13);
        send_paused = 1;
        wait (coords_due.size() == 0);
        send_paused = 0;
      end
      drain();
    end
    configure(64, 1, 1);
    for (int i = 0; i < 26; i++) rand_fracs.push_back(random_fraction());
    drain();

    repeat (100) @(posedge clk);
    $display("Sent %0d random fractions over %0d register writes, checked %0d coordinates.",
             n_items, n_cfg, n_coords);
    if (n_errors == 0 && coords_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d coordinates missing", n_errors, coords_due.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/maxlhc_pkg.sv
hw/rtl/maxlhc_ram.sv
hw/rtl/maxlhc_dp.sv
hw/rtl/maxlhc_ctrl.sv
hw/rtl/maximin_latin_hypercube_sampler.sv
tb/sv/maximin_latin_hypercube_sampler_tb.sv
